// ===== hdl/mssc_pkg.sv =====
// Shared types, operation codes and constants for the matrix store with search and count.
package mssc_pkg;

  localparam int DEF_ROWS = 8;
  localparam int DEF_COLS = 8;
  localparam int WORD_W   = 32;
  localparam int COUNT_W  = 17;
  localparam int FUNC_W   = 3;
  localparam int INDEX_W  = 8;

  // Operation codes carried in the func field.
  localparam logic [FUNC_W-1:0] FUNC_WRITE  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_COUNT  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_ROW    = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_COLUMN = 3'd4;

  // Value returned by a read with an out-of-range index.
  localparam logic signed [WORD_W-1:0] READ_FAULT_WORD = -32'sd1;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic [INDEX_W-1:0]       row_index;
    logic [INDEX_W-1:0]       col_index;
    logic signed [WORD_W-1:0] operand_value;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] read_data;
    logic                     found;
    logic [COUNT_W-1:0]       match_count;
    logic                     index_fault;
  } out_item_t;

  // Control from the sequencer to the compare and count unit.
  typedef struct packed {
    logic clear;
    logic enable;
  } match_ctl_t;

endpackage

// ===== hdl/mssc_match.sv =====
// Shared compare unit that counts stored words equal to the search key.
module mssc_match (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mssc_pkg::match_ctl_t               ctl,
  input  logic signed [mssc_pkg::WORD_W-1:0] word,
  input  logic signed [mssc_pkg::WORD_W-1:0] key,
  output logic [mssc_pkg::COUNT_W-1:0]       match_count,
  output logic                               found
);
  import mssc_pkg::*;

  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] count_nxt;
  logic               found_r;
  logic               found_nxt;

  always_comb begin
    count_nxt = count_r;
    found_nxt = found_r;
    if (ctl.clear) begin
      count_nxt = '0;
      found_nxt = 1'b0;
    end else if (ctl.enable && (word == key)) begin
      count_nxt = count_r + COUNT_W'(1);
      found_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      found_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      found_r <= found_nxt;
    end
  end

  assign match_count = count_r;
  assign found       = found_r;

endmodule

// ===== hdl/matrix_store_search_count.sv =====
// Top level of the matrix store with write, read, count-all, row search and column search.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------
//   in_     | input     | in_valid / in_stall  | in_data  (in_item_t)
//   out_    | output    | out_valid / out_stall| out_data (out_item_t)
//
// Every transaction gives exactly one result transaction. A write goes straight to the
// finish state; a read scans one word, a count-all all ROWS*COLS words, a row search
// COLS words and a column search ROWS words, paced by the single memory read port,
// which feeds one word per cycle to the shared compare unit. A bad index skips the scan.
// After reset a clearing pass writes zero to all ROWS*COLS words, one per cycle, and
// in_stall stays high for those cycles. A stalled result sits in the output register
// while the block already accepts the next transaction; that transaction only waits
// at its end for the output register to free up.
module matrix_store_search_count #(
  parameter int ROWS = mssc_pkg::DEF_ROWS,
  parameter int COLS = mssc_pkg::DEF_COLS
) (
  input  logic                rst_n,
  input  logic                clk,
  input  logic                in_valid,
  output logic                in_stall,
  input  mssc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mssc_pkg::out_item_t out_data
);
  import mssc_pkg::*;

  localparam int DEPTH  = ROWS * COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PROD_W = 2 * INDEX_W + 1;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0] LAST_COL  = ADDR_W'(COLS - 1);
  localparam logic [ADDR_W-1:0] LAST_ROW  = ADDR_W'(ROWS - 1);
  localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLS);
  localparam logic [ADDR_W-1:0] UNIT_STEP = ADDR_W'(1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // The word store. It has no reset of its own; the clearing pass zeroes it.
  logic signed [WORD_W-1:0] mem [DEPTH];

  state_t                   state_r, state_nxt;
  logic [ADDR_W-1:0]        clr_addr_r, clr_addr_nxt;
  logic [FUNC_W-1:0]        func_r, func_nxt;
  logic signed [WORD_W-1:0] operand_r, operand_nxt;
  logic                     fault_r, fault_nxt;
  logic [ADDR_W-1:0]        addr_r, addr_nxt;
  logic [ADDR_W-1:0]        stride_r, stride_nxt;
  logic [ADDR_W-1:0]        steps_left_r, steps_left_nxt;
  logic                     q_valid_r, q_valid_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_data_r, out_data_nxt;
  logic signed [WORD_W-1:0] mem_q_r;

  logic                     accept;
  logic                     row_ok;
  logic                     col_ok;
  logic [PROD_W-1:0]        row_base_wide;
  logic [ADDR_W-1:0]        row_base;
  logic [ADDR_W-1:0]        cell_addr;
  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_waddr;
  logic signed [WORD_W-1:0] mem_wdata;
  logic                     out_free;
  out_item_t                result;
  match_ctl_t               match_ctl;
  logic [COUNT_W-1:0]       match_count;
  logic                     match_found;

  // Index decode: range checks and the row-major word address.
  assign row_ok        = {1'b0, in_data.row_index} < (INDEX_W + 1)'(ROWS);
  assign col_ok        = {1'b0, in_data.col_index} < (INDEX_W + 1)'(COLS);
  assign row_base_wide = PROD_W'(in_data.row_index) * PROD_W'(COLS);
  assign row_base      = ADDR_W'(row_base_wide);
  assign cell_addr     = ADDR_W'(row_base_wide + PROD_W'(in_data.col_index));

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // The shared compare unit sees one stored word per cycle during a scan.
  assign match_ctl.clear  = accept;
  assign match_ctl.enable = q_valid_r;

  mssc_match u_match (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (match_ctl),
    .word        (mem_q_r),
    .key         (operand_r),
    .match_count (match_count),
    .found       (match_found)
  );

  // Result assembly once the scan has drained.
  always_comb begin
    result = '0;
    result.index_fault = fault_r;
    case (func_r)
      FUNC_READ: begin
        result.read_data = fault_r ? READ_FAULT_WORD : mem_q_r;
      end
      FUNC_COUNT: begin
        result.match_count = match_count;
        result.found       = (match_count != '0);
      end
      FUNC_ROW, FUNC_COLUMN: begin
        result.found = match_found && !fault_r;
      end
      default: begin
        result = result;
      end
    endcase
  end

  // Sequencer: decodes a transaction, walks the store address by address and
  // hands the finished result to the output register.
  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    func_nxt       = func_r;
    operand_nxt    = operand_r;
    fault_nxt      = fault_r;
    addr_nxt       = addr_r;
    stride_nxt     = stride_r;
    steps_left_nxt = steps_left_r;
    q_valid_nxt    = (state_r == ST_SCAN);
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;

    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + UNIT_STEP;
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          func_nxt       = in_data.func;
          operand_nxt    = in_data.operand_value;
          fault_nxt      = 1'b0;
          stride_nxt     = UNIT_STEP;
          steps_left_nxt = '0;
          state_nxt      = ST_FINISH;
          case (in_data.func)
            FUNC_WRITE: begin
              fault_nxt = !(row_ok && col_ok);
            end
            FUNC_READ: begin
              if (row_ok && col_ok) begin
                addr_nxt  = cell_addr;
                state_nxt = ST_SCAN;
              end else begin
                fault_nxt = 1'b1;
              end
            end
            FUNC_COUNT: begin
              addr_nxt       = '0;
              steps_left_nxt = LAST_ADDR;
              state_nxt      = ST_SCAN;
            end
            FUNC_ROW: begin
              if (row_ok) begin
                addr_nxt       = row_base;
                steps_left_nxt = LAST_COL;
                state_nxt      = ST_SCAN;
              end else begin
                fault_nxt = 1'b1;
              end
            end
            FUNC_COLUMN: begin
              if (col_ok) begin
                addr_nxt       = ADDR_W'(in_data.col_index);
                stride_nxt     = ROW_STEP;
                steps_left_nxt = LAST_ROW;
                state_nxt      = ST_SCAN;
              end else begin
                fault_nxt = 1'b1;
              end
            end
            default: begin
              fault_nxt = 1'b0;
            end
          endcase
        end
      end
      ST_SCAN: begin
        addr_nxt       = addr_r + stride_r;
        steps_left_nxt = steps_left_r - UNIT_STEP;
        if (steps_left_r == '0) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The last word read is in the compare unit this cycle.
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = result;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      q_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      q_valid_r   <= q_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r       <= func_nxt;
    operand_r    <= operand_nxt;
    fault_r      <= fault_nxt;
    addr_r       <= addr_nxt;
    stride_r     <= stride_nxt;
    steps_left_r <= steps_left_nxt;
    out_data_r   <= out_data_nxt;
  end

  // Single write port, shared by the clearing pass and write transactions.
  assign mem_we    = (state_r == ST_CLEAR) ||
                     (accept && (in_data.func == FUNC_WRITE) && row_ok && col_ok);
  assign mem_waddr = (state_r == ST_CLEAR) ? clr_addr_r : cell_addr;
  assign mem_wdata = (state_r == ST_CLEAR) ? '0 : in_data.operand_value;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // Registered read port, stepped by the sequencer during a scan.
  always_ff @(posedge clk) begin
    if (state_r == ST_SCAN) begin
      mem_q_r <= mem[addr_r];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hdl/mssc_checker.sv =====
// Port-level checker for the matrix store with search and count, and its bind.
module mssc_port_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input mssc_pkg::out_item_t out_data
);
  import mssc_pkg::*;

  // The clearing pass holds off input transactions right after reset.
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input accepted during the clearing pass");

  // One transaction at a time: the block is busy in the cycle after an accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second transaction accepted back to back");

  // A nonzero count only comes from a count-all, which sets found and no fault.
  a_count_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.match_count != '0)) |->
      (out_data.found && !out_data.index_fault && (out_data.read_data == '0)))
    else $error("match count inconsistent with other result fields");

  // A stalled result stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind matrix_store_search_count mssc_port_checker u_mssc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
